// ===== rtl/skht_pkg.sv =====
`default_nettype none
package skht_pkg;
    localparam int TABLE_DEPTH = 64;
    localparam int KEY_CHARS   = 63;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int IDX_W       = $clog2(KEY_CHARS + 1);
    localparam int LEN_W       = IDX_W + 1;
    localparam int TS_W        = 7;
    localparam int HASH_W      = 64;
    localparam int ROW_W       = 20;
    localparam int COL_W       = 14;
    localparam int STATUS_W    = 2;
    localparam int KEY_DEPTH   = TABLE_DEPTH * (2 ** IDX_W);

    localparam logic [HASH_W-1:0] HASH_SEED = 64'd5381;
    localparam logic              MODE_PUT  = 1'b0;
    localparam logic              MODE_GET  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_MISS    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_TOOLONG = 2'd2;

    typedef struct packed {
        logic              mode;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic [HASH_W-1:0] hash;
        logic [LEN_W-1:0]  len;
    } cmd_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ROW_W-1:0]    row;
        logic [COL_W-1:0]    col;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] idx;
        logic [7:0]       data;
    } pend_wr_t;
endpackage
`default_nettype wire

// ===== rtl/skht_front.sv =====
`default_nettype none
module skht_front import skht_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic        s_mode,
    input  wire logic [7:0]  s_key_char,
    input  wire logic [ROW_W-1:0] s_row_in,
    input  wire logic [COL_W-1:0] s_col_in,
    output logic             push,
    output cmd_t             push_cmd,
    input  wire logic        fifo_full,
    input  wire logic        done,
    output pend_wr_t         pend_wr
);
    logic              busy_reg, busy_next;
    logic [HASH_W-1:0] hash_reg, hash_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic              acc;

    assign s_ready = !busy_reg && !fifo_full;
    assign acc     = s_valid && s_ready;

    always_comb begin
        busy_next    = busy_reg;
        hash_next    = hash_reg;
        len_next     = len_reg;
        push         = 1'b0;
        pend_wr.en   = 1'b0;
        pend_wr.idx  = len_reg[IDX_W-1:0];
        pend_wr.data = s_key_char;
        push_cmd.mode = s_mode;
        push_cmd.row  = s_row_in;
        push_cmd.col  = s_col_in;
        push_cmd.hash = hash_reg;
        push_cmd.len  = len_reg;
        if (done) begin
            busy_next = 1'b0;
        end
        if (acc) begin
            if (s_key_char == 8'd0) begin
                push      = 1'b1;
                busy_next = 1'b1;
                hash_next = HASH_SEED;
                len_next  = '0;
            end else begin
                hash_next = (hash_reg << 5) + hash_reg + {{(HASH_W-8){1'b0}}, s_key_char};
                if (len_reg < LEN_W'(KEY_CHARS)) begin
                    pend_wr.en = 1'b1;
                    len_next   = len_reg + LEN_W'(1);
                end else begin
                    len_next = LEN_W'(KEY_CHARS + 1);
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            hash_reg <= HASH_SEED;
            len_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            hash_reg <= hash_next;
            len_reg  <= len_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/skht_cmd_fifo.sv =====
`default_nettype none
module skht_cmd_fifo import skht_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    input  wire logic pop,
    output logic      empty,
    output cmd_t      pop_cmd
);
    cmd_t       mem_reg [2];
    logic       wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign pop_cmd = mem_reg[rp_reg];

    always_comb begin
        wp_next  = wp_reg;
        rp_next  = rp_reg;
        cnt_next = cnt_reg;
        if (push && !full) begin
            wp_next  = !wp_reg;
            cnt_next = cnt_next + 2'd1;
        end
        if (pop && !empty) begin
            rp_next  = !rp_reg;
            cnt_next = cnt_next - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (push && !full) begin
            mem_reg[wp_reg] <= push_cmd;
        end
        if (!aresetn) begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= '0;
        end else begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/skht_back.sv =====
`default_nettype none
module skht_back import skht_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_we,
    input  wire logic [TS_W-1:0] cfg_value,
    input  wire pend_wr_t        pend_wr,
    input  wire logic            q_empty,
    input  wire cmd_t            q_cmd,
    output logic                 pop,
    output logic                 res_valid,
    output res_t                 res,
    input  wire logic            res_ack,
    output logic                 done
);
    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_DIV  = 9'b000000010,
        S_PRD  = 9'b000000100,
        S_PCHK = 9'b000001000,
        S_CRD  = 9'b000010000,
        S_CCHK = 9'b000100000,
        S_WRD  = 9'b001000000,
        S_WWR  = 9'b010000000,
        S_RESP = 9'b100000000
    } state_t;

    state_t            state_reg, state_next;
    cmd_t              cmd_reg, cmd_next;
    logic [HASH_W-1:0] hsh_reg, hsh_next;
    logic [SLOT_W:0]   rem_reg, rem_next;
    logic [5:0]        cnt_reg, cnt_next;
    logic [SLOT_W-1:0] pos_reg, pos_next;
    logic [TS_W-1:0]   probe_reg, probe_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    res_t              res_reg, res_next;
    logic [TS_W-1:0]   ts_reg;
    logic [TABLE_DEPTH-1:0] used_reg;

    logic [7:0]       pend_mem [2**IDX_W];
    logic [7:0]       key_mem  [KEY_DEPTH];
    logic [LEN_W-1:0] len_mem  [TABLE_DEPTH];
    logic [ROW_W-1:0] row_mem  [TABLE_DEPTH];
    logic [COL_W-1:0] col_mem  [TABLE_DEPTH];

    logic [7:0]       pend_rd_reg, key_rd_reg;
    logic [LEN_W-1:0] len_rd_reg;
    logic [ROW_W-1:0] row_rd_reg;
    logic [COL_W-1:0] col_rd_reg;

    logic             key_we, meta_we;
    logic [SLOT_W+1:0] div_try;
    logic             idx_end;
    logic             last_probe;
    logic [SLOT_W-1:0] pos_inc;
    logic [TS_W-1:0]  cfg_clamped;

    assign div_try    = {rem_reg, hsh_reg[HASH_W-1]};
    assign idx_end    = {1'b0, idx_reg} == cmd_reg.len;
    assign last_probe = probe_reg + TS_W'(1) == ts_reg;
    assign pos_inc    = ({1'b0, pos_reg} + TS_W'(1) == ts_reg) ? '0 : pos_reg + SLOT_W'(1);
    assign cfg_clamped = (cfg_value == '0) ? TS_W'(1) :
                         (cfg_value > TS_W'(TABLE_DEPTH)) ? TS_W'(TABLE_DEPTH) : cfg_value;

    assign res_valid = state_reg == S_RESP;
    assign res       = res_reg;
    assign done      = res_valid && res_ack;
    assign pop       = state_reg == S_IDLE && !q_empty;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        hsh_next   = hsh_reg;
        rem_next   = rem_reg;
        cnt_next   = cnt_reg;
        pos_next   = pos_reg;
        probe_next = probe_reg;
        idx_next   = idx_reg;
        res_next   = res_reg;
        key_we     = 1'b0;
        meta_we    = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (!q_empty) begin
                    cmd_next = q_cmd;
                    hsh_next = q_cmd.hash;
                    rem_next = '0;
                    cnt_next = '0;
                    res_next = '{status: ST_MISS, row: '0, col: '0};
                    if (q_cmd.len > LEN_W'(KEY_CHARS)) begin
                        res_next.status = ST_TOOLONG;
                        state_next      = S_RESP;
                    end else begin
                        state_next = S_DIV;
                    end
                end
            end
            S_DIV: begin
                if (div_try >= {1'b0, ts_reg}) begin
                    rem_next = (SLOT_W+1)'(div_try - {1'b0, ts_reg});
                end else begin
                    rem_next = div_try[SLOT_W:0];
                end
                hsh_next = hsh_reg << 1;
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63) begin
                    pos_next   = rem_next[SLOT_W-1:0];
                    probe_next = '0;
                    state_next = S_PRD;
                end
            end
            S_PRD: begin
                state_next = S_PCHK;
            end
            S_PCHK: begin
                idx_next = '0;
                if (!used_reg[pos_reg]) begin
                    state_next = (cmd_reg.mode == MODE_PUT) ? S_WRD : S_RESP;
                end else if (len_rd_reg == cmd_reg.len) begin
                    state_next = S_CRD;
                end else begin
                    probe_next = probe_reg + TS_W'(1);
                    pos_next   = pos_inc;
                    state_next = last_probe ? S_RESP : S_PRD;
                end
            end
            S_CRD: begin
                if (idx_end) begin
                    if (cmd_reg.mode == MODE_PUT) begin
                        idx_next   = '0;
                        state_next = S_WRD;
                    end else begin
                        res_next   = '{status: ST_OK, row: row_rd_reg, col: col_rd_reg};
                        state_next = S_RESP;
                    end
                end else begin
                    state_next = S_CCHK;
                end
            end
            S_CCHK: begin
                if (pend_rd_reg == key_rd_reg) begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CRD;
                end else begin
                    probe_next = probe_reg + TS_W'(1);
                    pos_next   = pos_inc;
                    state_next = last_probe ? S_RESP : S_PRD;
                end
            end
            S_WRD: begin
                if (idx_end) begin
                    meta_we         = 1'b1;
                    res_next.status = ST_OK;
                    state_next      = S_RESP;
                end else begin
                    state_next = S_WWR;
                end
            end
            S_WWR: begin
                key_we     = 1'b1;
                idx_next   = idx_reg + IDX_W'(1);
                state_next = S_WRD;
            end
            S_RESP: begin
                if (res_ack) begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (pend_wr.en) begin
            pend_mem[pend_wr.idx] <= pend_wr.data;
        end
        if (key_we) begin
            key_mem[{pos_reg, idx_reg}] <= pend_rd_reg;
        end
        if (meta_we) begin
            len_mem[pos_reg] <= cmd_reg.len;
            row_mem[pos_reg] <= cmd_reg.row;
            col_mem[pos_reg] <= cmd_reg.col;
        end
        pend_rd_reg <= pend_mem[idx_reg];
        key_rd_reg  <= key_mem[{pos_reg, idx_reg}];
        len_rd_reg  <= len_mem[pos_reg];
        row_rd_reg  <= row_mem[pos_reg];
        col_rd_reg  <= col_mem[pos_reg];
    end

    always_ff @(posedge aclk) begin
        cmd_reg   <= cmd_next;
        hsh_reg   <= hsh_next;
        cnt_reg   <= cnt_next;
        idx_reg   <= idx_next;
        res_reg   <= res_next;
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ts_reg    <= TS_W'(TABLE_DEPTH);
            used_reg  <= '0;
            rem_reg   <= '0;
            pos_reg   <= '0;
            probe_reg <= '0;
        end else begin
            state_reg <= state_next;
            rem_reg   <= rem_next;
            pos_reg   <= pos_next;
            probe_reg <= probe_next;
            if (cfg_we) begin
                ts_reg   <= cfg_clamped;
                used_reg <= '0;
            end else if (meta_we) begin
                used_reg[pos_reg] <= 1'b1;
            end
        end
    end

    a_rem_below_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_IDLE) |-> ({1'b0, rem_reg} < {1'b0, ts_reg}))
        else $error("remainder not below table size");
    a_pos_in_table: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PCHK) |-> ({1'b0, pos_reg} < ts_reg))
        else $error("probe slot outside table");
    a_write_marks_used: assert property (@(posedge aclk) disable iff (!aresetn)
        (meta_we && !cfg_we) |=> used_reg[$past(pos_reg)])
        else $error("written slot not marked used");
endmodule
`default_nettype wire

// ===== rtl/string_key_hash_table_top.sv =====
// Channel  | Handshake              | Word
// s_       | s_valid / s_ready      | s_mode, s_key_char, s_row_in, s_col_in
// m_       | m_valid / m_ready      | m_status, m_row_out, m_col_out
// cfg_     | cfg_valid / cfg_ready  | cfg_data (table_size)
// A key character is taken whenever s_ready is high. A terminator blocks the
// input until its result is registered: first the bit-serial hash remainder,
// then for each probed slot a read and check, with one compare per key
// character, and on a put a copy of each key character. Reset is synchronous
// and clears used marks at once; the output register holds a result while
// m_ready is low.
`default_nettype none
module string_key_hash_table_top import skht_pkg::*; (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire logic             s_mode,
    input  wire logic [7:0]       s_key_char,
    input  wire logic [ROW_W-1:0] s_row_in,
    input  wire logic [COL_W-1:0] s_col_in,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [STATUS_W-1:0]   m_status,
    output logic [ROW_W-1:0]      m_row_out,
    output logic [COL_W-1:0]      m_col_out,
    input  wire logic             cfg_valid,
    output logic                  cfg_ready,
    input  wire logic [TS_W-1:0]  cfg_data
);
    cmd_t     push_cmd, pop_cmd;
    logic     push, pop, q_full, q_empty, done;
    pend_wr_t pend_wr;
    logic     res_valid, res_ack;
    res_t     res;
    logic     m_valid_reg, m_valid_next;
    res_t     out_reg;

    assign cfg_ready = 1'b1;

    skht_front u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_mode, .s_key_char, .s_row_in, .s_col_in,
        .push, .push_cmd, .fifo_full(q_full), .done, .pend_wr
    );

    skht_cmd_fifo u_fifo (
        .aclk, .aresetn, .push, .push_cmd, .full(q_full), .pop, .empty(q_empty), .pop_cmd
    );

    skht_back u_back (
        .aclk, .aresetn, .cfg_we(cfg_valid), .cfg_value(cfg_data), .pend_wr,
        .q_empty, .q_cmd(pop_cmd), .pop, .res_valid, .res, .res_ack, .done
    );

    assign res_ack = res_valid && (!m_valid_reg || m_ready);

    always_comb begin
        m_valid_next = m_valid_reg;
        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (res_ack) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_ack) begin
            out_reg <= res;
        end
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_status  = out_reg.status;
    assign m_row_out = out_reg.row;
    assign m_col_out = out_reg.col;
endmodule
`default_nettype wire
